[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package dq_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH_BACK  = 2'd0,
      REQ_PUSH_FRONT = 2'd1,
      REQ_POP_BACK   = 2'd2,
      REQ_POP_FRONT  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD       = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_POP_FRONT  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        was_empty;
   } cell_ctrl_type;

endpackage

[rtl/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell
// One deque slot: holds an item and a marker for the last occupied slot,
// shifting both toward either neighbor as the request demands.
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int ITEM_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dq_pkg::cell_ctrl_type ctrl,
   input  logic [ITEM_BITS-1:0]  push_item,
   input  logic [ITEM_BITS-1:0]  prev_item,
   input  logic                  prev_mark,
   input  logic [ITEM_BITS-1:0]  next_item,
   input  logic                  next_mark,
   output logic [ITEM_BITS-1:0]  item,
   output logic                  mark,
   output logic [ITEM_BITS-1:0]  tap
);

   logic [ITEM_BITS-1:0] item_ff;
   logic [ITEM_BITS-1:0] item_in;
   logic                 mark_ff;
   logic                 mark_in;

   always_comb begin
      item_in = item_ff;
      mark_in = mark_ff;
      unique case (ctrl.op)
         dq_pkg::OP_PUSH_BACK: begin
            if (prev_mark) begin
               item_in = push_item;
            end
            mark_in = prev_mark;
         end
         dq_pkg::OP_PUSH_FRONT: begin
            item_in = prev_item;
            mark_in = prev_mark;
         end
         dq_pkg::OP_POP_BACK: begin
            mark_in = next_mark;
         end
         dq_pkg::OP_POP_FRONT: begin
            item_in = next_item;
            mark_in = next_mark;
         end
         default: begin
            item_in = item_ff;
            mark_in = mark_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
      item_ff <= item_in;
   end

   assign item = item_ff;
   assign mark = mark_ff;
   assign tap  = mark_ff ? item_ff : '0;

endmodule

[rtl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Request decode, occupancy count and response strobe for the cell chain.
// ----------------------------------------------------------------------------
module dq_ctrl #(
   parameter int DEPTH    = 16,
   parameter int CNT_BITS = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_type,
   output logic                  busy,
   output dq_pkg::cell_ctrl_type ctrl,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [CNT_BITS-1:0]   count
);

   logic                  strobe_ff;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  full;
   logic                  empty;
   dq_pkg::req_code_type  code;

   assign full  = (count_ff == CNT_BITS'(DEPTH));
   assign empty = (count_ff == '0);
   assign code  = dq_pkg::req_code_type'(req_type);

   always_comb begin
      ctrl.op        = dq_pkg::OP_HOLD;
      ctrl.was_empty = empty;
      status_in      = dq_pkg::STATUS_DONE;
      count_in       = count_ff;
      if (start) begin
         unique case (code)
            dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_FULL;
               end else begin
                  ctrl.op  = (code == dq_pkg::REQ_PUSH_BACK) ?
                             dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            dq_pkg::REQ_POP_BACK, dq_pkg::REQ_POP_FRONT: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_EMPTY;
               end else begin
                  ctrl.op  = (code == dq_pkg::REQ_POP_BACK) ?
                             dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
                  count_in = count_ff - CNT_BITS'(1);
               end
            end
            default: begin
               ctrl.op = dq_pkg::OP_HOLD;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         strobe_ff <= start;
         count_ff  <= count_in;
      end
      status_ff <= status_in;
   end

   assign busy       = 1'b0;
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign count      = count_ff;

endmodule

[rtl/double_ended_queue_top.sv]
// The response strobe is registered and rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, as every request that is not
// refused as full or empty is a shift or marker move in the cell chain.
// Reset clears the occupancy count and the last-slot markers (empty deque);
// stored items are unknown until written.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque built from a row of shifting cells with a last-slot marker.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH     = 16,
   parameter int ITEM_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_type,
   input  logic [31:0]                  req_item_value,
   output logic                         rsp_strobe,
   output logic [1:0]                   rsp_status,
   output logic [31:0]                  rsp_front_item,
   output logic [31:0]                  rsp_back_item,
   output logic                         rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   dq_pkg::cell_ctrl_type ctrl;
   logic [CNT_BITS-1:0]   count;
   logic [ITEM_BITS-1:0]  push_item;
   logic [ITEM_BITS-1:0]  item_w [DEPTH];
   logic [ITEM_BITS-1:0]  tap_w  [DEPTH];
   logic                  mark_w [DEPTH];
   logic [ITEM_BITS-1:0]  back_item;

   assign push_item = ITEM_BITS'(req_item_value);

   dq_ctrl #(
      .DEPTH    (DEPTH),
      .CNT_BITS (CNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .busy       (busy),
      .ctrl       (ctrl),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .count      (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ITEM_BITS-1:0] prev_item;
      logic                 prev_mark;
      logic [ITEM_BITS-1:0] next_item;
      logic                 next_mark;

      if (i == 0) begin : g_first
         assign prev_item = push_item;
         assign prev_mark = ctrl.was_empty;
      end else begin : g_mid
         assign prev_item = item_w[i-1];
         assign prev_mark = mark_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_item = '0;
         assign next_mark = 1'b0;
      end else begin : g_inner
         assign next_item = item_w[i+1];
         assign next_mark = mark_w[i+1];
      end

      dq_cell #(
         .ITEM_BITS (ITEM_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .push_item (push_item),
         .prev_item (prev_item),
         .prev_mark (prev_mark),
         .next_item (next_item),
         .next_mark (next_mark),
         .item      (item_w[i]),
         .mark      (mark_w[i]),
         .tap       (tap_w[i])
      );
   end

   always_comb begin
      back_item = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_item = back_item | tap_w[i];
      end
   end

   assign rsp_is_empty   = (count == '0);
   assign rsp_front_item = rsp_is_empty ? 32'd0 : 32'(item_w[0]);
   assign rsp_back_item  = 32'(back_item);
   assign rsp_occupancy  = count;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded double-ended queue. A shadow deque,
// kept as a ring of slots with a head index and a count, predicts the view
// that follows each accepted request. Directed rows cover empty and full
// corners and head wrap. Random traffic then swings between filling and
// draining phases so that both limits are hit again and again, while the
// sender idles in bursts.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DEPTH        = 16;
   localparam int OCC_BITS     = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 1100;
   localparam int PAUSE_AT     = 550;
   localparam int AWAIT_DEPTH  = 16;

   typedef struct packed {
      dq_pkg::status_type  status;
      logic [31:0]         front_item;
      logic [31:0]         back_item;
      logic                is_empty;
      logic [OCC_BITS-1:0] occupancy;
   } deque_view_type;

   typedef struct {
      dq_pkg::req_code_type op;
      logic [31:0]          value;
      logic                 typed;
      deque_view_type       view;
   } step_row_type;

   localparam deque_view_type NO_VIEW = '0;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_type;
   logic [31:0]         req_item_value;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [31:0]         rsp_front_item;
   logic [31:0]         rsp_back_item;
   logic                rsp_is_empty;
   logic [OCC_BITS-1:0] rsp_occupancy;

   // typed expectation travels with the request it belongs to
   logic                req_typed;
   deque_view_type      req_typed_view;

   logic [31:0]         shadow_slots [DEPTH];
   int                  shadow_head;
   int                  shadow_count;
   deque_view_type      awaited_ring [AWAIT_DEPTH];
   int                  awaited_wr = 0;
   int                  awaited_rd = 0;
   int                  mismatch_count;

   step_row_type directed_rows [25] = '{
      '{dq_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1,
        '{dq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 1'b1, 5'd0}},
      '{dq_pkg::REQ_POP_FRONT,  32'hFFFF_FFFF, 1'b1,
        '{dq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 1'b1, 5'd0}},
      '{dq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
        '{dq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1}},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0000_0000, 1'b1,
        '{dq_pkg::STATUS_DONE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 5'd2}},
      '{dq_pkg::REQ_POP_FRONT,  32'h1234_5678, 1'b1,
        '{dq_pkg::STATUS_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd1}},
      '{dq_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1,
        '{dq_pkg::STATUS_DONE, 32'h0, 32'h0, 1'b1, 5'd0}},
      '{dq_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1,
        '{dq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 1'b1, 5'd0}},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0000_0001, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'h8000_0000, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0000_0002, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'h4000_0000, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0000_0004, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'h2000_0000, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'hA5A5_5A5A, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'h5A5A_A5A5, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0000_FFFF, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'hFFFF_0000, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'hF0F0_F0F0, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h3333_3333, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'hCCCC_CCCC, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFE, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_BACK,  32'hDEAD_0001, 1'b0, NO_VIEW},
      '{dq_pkg::REQ_PUSH_FRONT, 32'hDEAD_0002, 1'b0, NO_VIEW}
   };

   double_ended_queue_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_front_item (rsp_front_item),
      .rsp_back_item  (rsp_back_item),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_occupancy  (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic advance_deque(input dq_pkg::req_code_type op, input logic [31:0] value,
                                output deque_view_type view);
      view = '0;
      view.status = dq_pkg::STATUS_DONE;
      case (op)
         dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               view.status = dq_pkg::STATUS_FULL;
            end else if (op == dq_pkg::REQ_PUSH_BACK) begin
               shadow_slots[(shadow_head + shadow_count) % DEPTH] = value;
               shadow_count++;
            end else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_slots[shadow_head] = value;
               shadow_count++;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               view.status = dq_pkg::STATUS_EMPTY;
            end else begin
               if (op == dq_pkg::REQ_POP_FRONT) shadow_head = (shadow_head + 1) % DEPTH;
               shadow_count--;
            end
         end
      endcase
      if (shadow_count != 0) begin
         view.front_item = shadow_slots[shadow_head];
         view.back_item  = shadow_slots[(shadow_head + shadow_count - 1) % DEPTH];
      end
      view.is_empty  = (shadow_count == 0);
      view.occupancy = OCC_BITS'(shadow_count);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 40)
         $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      mismatch_count++;
   endtask

   task automatic compare_view(input deque_view_type got, input deque_view_type want);
      if (got.status !== want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.front_item !== want.front_item)
         report_mismatch("front_item", got.front_item, want.front_item);
      if (got.back_item !== want.back_item)
         report_mismatch("back_item", got.back_item, want.back_item);
      if (got.is_empty !== want.is_empty)
         report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
      if (got.occupancy !== want.occupancy)
         report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
   endtask

   always @(posedge clock) begin
      deque_view_type predicted;
      deque_view_type observed;
      if (!reset) begin
         if (start && !busy) begin
            advance_deque(dq_pkg::req_code_type'(req_type), req_item_value, predicted);
            awaited_ring[awaited_wr % AWAIT_DEPTH] = req_typed ? req_typed_view : predicted;
            awaited_wr++;
         end
         if (rsp_strobe) begin
            observed.status     = dq_pkg::status_type'(rsp_status);
            observed.front_item = rsp_front_item;
            observed.back_item  = rsp_back_item;
            observed.is_empty   = rsp_is_empty;
            observed.occupancy  = rsp_occupancy;
            if (awaited_wr == awaited_rd) begin
               report_mismatch("unrequested response", 32'(rsp_status), 32'h0);
            end else begin
               compare_view(observed, awaited_ring[awaited_rd % AWAIT_DEPTH]);
               awaited_rd++;
            end
         end
      end
   end

   task automatic issue_request(input dq_pkg::req_code_type op, input logic [31:0] value,
                                input logic typed, input deque_view_type view);
      start          <= 1'b1;
      req_type       <= op;
      req_item_value <= value;
      req_typed      <= typed;
      req_typed_view <= view;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_responses();
      @(posedge clock);
      while (awaited_wr != awaited_rd) @(posedge clock);
   endtask

   initial begin
      dq_pkg::req_code_type op;
      logic [31:0]          value;
      int                   burst_left;
      int                   gap;
      int                   phase_left;
      logic                 filling;

      reset          = 1'b1;
      start          = 1'b0;
      req_type       = dq_pkg::REQ_PUSH_BACK;
      req_item_value = '0;
      req_typed      = 1'b0;
      req_typed_view = NO_VIEW;
      shadow_head    = 0;
      shadow_count   = 0;
      mismatch_count = 0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue_request(directed_rows[i].op, directed_rows[i].value,
                       directed_rows[i].typed, directed_rows[i].view);

      burst_left = 0;
      phase_left = 0;
      filling    = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) begin
            start <= 1'b0;
            drain_responses();
         end else if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 5);
            if (gap > 0) begin
               start          <= 1'b0;
               req_type       <= 2'($urandom_range(3));
               req_item_value <= $urandom;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;

         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 40);
            filling    = ~filling;
         end
         phase_left--;

         if ($urandom_range(99) < (filling ? 85 : 15))
            op = $urandom_range(1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK;
         else
            op = $urandom_range(1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK;
         value = $urandom;
         if ($urandom_range(15) == 0) value = $urandom_range(1) ? '1 : '0;
         issue_request(op, value, 1'b0, NO_VIEW);
      end

      start <= 1'b0;
      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && awaited_wr == awaited_rd)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
